// ----- rtl/pse_pkg.sv -----
// Shared constants, codes and types of the postfix stack evaluator.
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_NUM  = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_EQ   = 3'd5,
        CMD_BAD  = 3'd6,
        CMD_NONE = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_EXPR = 3'd1,
        ST_MANY = 3'd2,
        ST_DIV0 = 3'd3,
        ST_OVF  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/pse_if.sv -----
// Token and result channel interfaces of the postfix stack evaluator.
interface pse_in_if;
    logic                              valid;
    logic                              ready;
    logic [pse_pkg::CMD_W-1:0]         cmd;
    logic signed [pse_pkg::DATA_W-1:0] operand;
    logic                              line_end;

    modport source (output valid, output cmd, output operand, output line_end, input ready);
    modport sink (input valid, input cmd, input operand, input line_end, output ready);
endinterface

interface pse_out_if;
    logic                              valid;
    logic                              ready;
    logic [pse_pkg::STATUS_W-1:0]      status;
    logic signed [pse_pkg::DATA_W-1:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink (input valid, input status, input result_value, output ready);
endinterface

// ----- rtl/pse_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/pse_divider.sv -----
// Shift-subtract signed divider, one quotient bit per cycle, truncating toward zero.
module pse_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pse_pkg::div_req_t req,
    output pse_pkg::div_rsp_t rsp
);
    import pse_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] steps_reg, steps_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    mb_reg, mb_next;

    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;
    logic                 fits;
    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;

    assign mag_a   = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
    assign mag_b   = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, mb_reg};
    assign fits    = !diff[DATA_W];

    always_comb
    begin
        busy_next  = busy_reg;
        steps_next = steps_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        mb_next    = mb_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            steps_next = DIV_CNT_W'(DIV_STEPS);
            neg_next   = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            rem_next   = '0;
            quo_next   = mag_a;
            mb_next    = mag_b;
        end
        else if (busy_reg)
        begin
            if (steps_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next   = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                quo_next   = {quo_reg[DATA_W-2:0], fits};
                steps_next = steps_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
    end

    assign rsp.done     = busy_reg && (steps_reg == '0);
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ----- rtl/postfix_stack_evaluator_top.sv -----
// Postfix evaluator top level: token sequencer around the operand stack RAM.
// Each token is first accepted (issue the stack RAM read), then executed and written back.
// A divide waits in S_DIV for the one-bit-per-cycle shift-subtract divider.
// A line-end token then passes through S_EMIT to load the result register, waiting while it is still full.
// Reset clears the stack count, line flags and result valid; stack RAM is not cleared.
module postfix_stack_evaluator_top (
    input  logic       clk,
    input  logic       rst_n,
    pse_in_if.sink     token,
    pse_out_if.source  result
);
    import pse_pkg::*;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DATA_W-1:0] operand_reg, operand_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic              finished_reg, finished_next;
    status_t           pending_reg, pending_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [PTR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [CNT_W-1:0]  count_m2;
    logic [DATA_W-1:0] mul_low;
    logic [DATA_W-1:0] alu_res;
    logic              accept;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pse_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign token.ready         = (state_reg == S_IDLE);
    assign accept              = token.valid && token.ready;
    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.result_value = out_value_reg;

    // Left operand sits one below the cached top of stack.
    assign count_m2  = count_reg - CNT_W'(2);
    assign mem_raddr = count_m2[PTR_W-1:0];
    assign mul_low   = mem_rdata * tos_reg;

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD: alu_res = mem_rdata + tos_reg;
            CMD_SUB: alu_res = mem_rdata - tos_reg;
            default: alu_res = mul_low;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        operand_next    = operand_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        tos_next        = tos_reg;
        finished_next   = finished_reg;
        pending_next    = pending_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[PTR_W-1:0];
        mem_wdata       = operand_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mem_rdata;
        div_req.divisor  = tos_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd_t'(token.cmd);
                    operand_next = token.operand;
                    last_next    = token.line_end;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = last_reg ? S_EMIT : S_IDLE;
                if (!finished_reg)
                begin
                    case (cmd_reg) inside
                        CMD_NUM:
                        begin
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                finished_next = 1'b1;
                                pending_next  = ST_OVF;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                tos_next   = operand_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                finished_next = 1'b1;
                                pending_next  = ST_EXPR;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_m2[PTR_W-1:0];
                                mem_wdata  = alu_res;
                                tos_next   = alu_res;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_DIV:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                finished_next = 1'b1;
                                pending_next  = ST_EXPR;
                            end
                            else if (tos_reg == '0)
                            begin
                                finished_next = 1'b1;
                                pending_next  = ST_DIV0;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                        CMD_EQ:
                        begin
                            finished_next = 1'b1;
                        end
                        CMD_BAD:
                        begin
                            finished_next = 1'b1;
                            pending_next  = ST_EXPR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_m2[PTR_W-1:0];
                    mem_wdata  = div_rsp.quotient;
                    tos_next   = div_rsp.quotient;
                    count_next = count_reg - CNT_W'(1);
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                // Hold until the result register is free or being drained.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    if (pending_reg != ST_OK)
                    begin
                        out_status_next = pending_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        out_status_next = ST_EXPR;
                    end
                    else if (count_reg > CNT_W'(1))
                    begin
                        out_status_next = ST_MANY;
                    end
                    else
                    begin
                        out_status_next = ST_OK;
                        out_value_next  = tos_reg;
                    end
                    count_next    = '0;
                    finished_next = 1'b0;
                    pending_next  = ST_OK;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            finished_reg  <= 1'b0;
            pending_reg   <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            finished_reg  <= finished_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        operand_reg    <= operand_next;
        last_reg       <= last_next;
        tos_reg        <= tos_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

endmodule

// ----- rtl/pse_checker.sv -----
// Port-level assertions for the postfix evaluator, bound to the top level.
module pse_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         tok_valid,
    input logic                         tok_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [pse_pkg::STATUS_W-1:0] res_status,
    input logic [pse_pkg::DATA_W-1:0]   res_value
);
    import pse_pkg::*;

    // A stalled result beat stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_status) && $stable(res_value))
        else $error("result payload changed while stalled");

    // Error statuses carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ST_OK) |-> (res_value == '0))
        else $error("nonzero value with error status");

    // Every token passes through the execute state before the next one is taken.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready |=> !tok_ready)
        else $error("token taken on back-to-back cycles");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (token.valid),
    .tok_ready  (token.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_value  (result.result_value)
);

// ----- tb/sv/tb_postfix_stack_evaluator_top.sv -----
// Self-checking testbench of the postfix stack evaluator: directed and random expression lines.
`timescale 1ns / 100ps

module tb_postfix_stack_evaluator_top;
    import pse_pkg::*;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] value;
    } line_result_t;

    logic clk;
    logic rst_n;

    pse_in_if  tok_if ();
    pse_out_if res_if ();

    postfix_stack_evaluator_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (tok_if),
        .result (res_if)
    );

    // Predicted evaluator state
    logic [DATA_W-1:0] opnd_stack [STACK_DEPTH];
    int                opnd_depth;
    bit                line_closed;
    status_t           line_code;
    line_result_t      line_results_due [$];

    int mismatch_count;
    int tokens_sent;
    int burst_left;
    bit tok_gaps_on;
    int res_mode;
    logic [7:0] res_mask;

    always #6 clk = ~clk;

    initial
    begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side stall pattern
    always @(negedge clk)
    begin
        res_mask <= {res_mask[6:0], res_mask[7]};
        case (res_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= 1'($urandom_range(0, 1));
            2: res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= res_mask[0];
        endcase
    end

    function automatic void report_mismatch(string what, logic [DATA_W-1:0] want,
                                            logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    always @(posedge clk)
    begin
        line_result_t due;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (line_results_due.size() == 0)
            begin
                report_mismatch("unexpected result beat", '0, res_if.result_value);
            end
            else
            begin
                due = line_results_due.pop_front();
                if (due.status !== res_if.status)
                    report_mismatch("status", DATA_W'(due.status), DATA_W'(res_if.status));
                if (due.value !== res_if.result_value)
                    report_mismatch("result_value", due.value, res_if.result_value);
            end
        end
    end

    // Advance the predicted stack by one accepted token
    function automatic void eval_token(cmd_t c, logic [DATA_W-1:0] v, bit le);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] mag_l;
        logic [DATA_W-1:0] mag_r;
        logic [DATA_W-1:0] res;
        line_result_t      out;
        if (!line_closed)
        begin
            case (c)
                CMD_NUM:
                begin
                    if (opnd_depth >= STACK_DEPTH)
                    begin
                        line_code   = ST_OVF;
                        line_closed = 1'b1;
                    end
                    else
                    begin
                        opnd_stack[opnd_depth] = v;
                        opnd_depth++;
                    end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                begin
                    if (opnd_depth < 2)
                    begin
                        line_code   = ST_EXPR;
                        line_closed = 1'b1;
                    end
                    else
                    begin
                        rhs = opnd_stack[opnd_depth-1];
                        lhs = opnd_stack[opnd_depth-2];
                        if (c == CMD_DIV && rhs == '0)
                        begin
                            line_code   = ST_DIV0;
                            line_closed = 1'b1;
                        end
                        else
                        begin
                            case (c)
                                CMD_ADD: res = lhs + rhs;
                                CMD_SUB: res = lhs - rhs;
                                CMD_MUL: res = lhs * rhs;
                                default:
                                begin
                                    // truncate toward zero on magnitudes, then fix the sign
                                    mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                                    mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                                    res   = mag_l / mag_r;
                                    if (lhs[DATA_W-1] != rhs[DATA_W-1])
                                        res = -res;
                                end
                            endcase
                            opnd_depth--;
                            opnd_stack[opnd_depth-1] = res;
                        end
                    end
                end
                CMD_EQ:
                    line_closed = 1'b1;
                CMD_BAD:
                begin
                    line_code   = ST_EXPR;
                    line_closed = 1'b1;
                end
                default: ;
            endcase
        end
        if (le)
        begin
            out.value = '0;
            if (line_code != ST_OK)
                out.status = line_code;
            else if (opnd_depth == 0)
                out.status = ST_EXPR;
            else if (opnd_depth > 1)
                out.status = ST_MANY;
            else
            begin
                out.status = ST_OK;
                out.value  = opnd_stack[0];
            end
            line_results_due.push_back(out);
            opnd_depth  = 0;
            line_closed = 1'b0;
            line_code   = ST_OK;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_token(cmd_t c, logic [DATA_W-1:0] v, bit le);
        int gap;
        if (tok_gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            tok_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        tok_if.valid    <= 1'b1;
        tok_if.cmd      <= c;
        tok_if.operand  <= v;
        tok_if.line_end <= le;
        @(posedge clk);
        while (!tok_if.ready)
            @(posedge clk);
        eval_token(c, v, le);
        tokens_sent++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        tok_if.valid <= 1'b0;
        while (line_results_due.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_line();
        int   nops;
        int   pushes;
        int   ops;
        int   d;
        int   end_kind;
        int   len;
        bit   fin;
        cmd_t c;
        if ($urandom_range(0, 9) < 8)
        begin
            // well-formed expression with random content and a random ending
            nops     = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
            pushes   = nops + 1;
            ops      = nops;
            d        = 0;
            end_kind = $urandom_range(0, 3);
            while (pushes + ops > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_token(CMD_NONE, $urandom, 1'b0);
                fin = (end_kind == 0) && (pushes + ops == 1);
                if (d >= 2 && ops > 0 && (pushes == 0 || $urandom_range(0, 1)))
                begin
                    c = cmd_t'($urandom_range(CMD_ADD, CMD_DIV));
                    send_token(c, $urandom, fin);
                    d--;
                    ops--;
                end
                else
                begin
                    send_token(CMD_NUM, pick_operand(), fin);
                    d++;
                    pushes--;
                end
            end
            case (end_kind)
                1: send_token(CMD_NONE, $urandom, 1'b1);
                2: send_token(CMD_EQ, $urandom, 1'b1);
                3:
                begin
                    // tokens after an equals sign are dropped
                    send_token(CMD_EQ, $urandom, 1'b0);
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++)
                    begin
                        c = cmd_t'($urandom_range(0, 7));
                        send_token(c, pick_operand(), k == len - 1);
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                c = cmd_t'($urandom_range(0, 7));
                send_token(c, (c == CMD_NUM) ? pick_operand() : $urandom, k == len - 1);
            end
        end
    endtask

    task automatic test_directed();
        tok_gaps_on = 1'b1;
        res_mode    = 1;
        // wrap on add, equals with junk after it
        send_token(CMD_NUM, 32'h7FFF_FFFF, 1'b0);
        send_token(CMD_NUM, 32'h0000_0001, 1'b0);
        send_token(CMD_ADD, $urandom, 1'b1);
        send_token(CMD_NUM, 32'h8000_0000, 1'b0);
        send_token(CMD_NUM, 32'h0000_0001, 1'b0);
        send_token(CMD_SUB, $urandom, 1'b0);
        send_token(CMD_EQ, $urandom, 1'b0);
        send_token(CMD_NUM, 32'h0000_0005, 1'b1);
        // most negative over minus one wraps
        send_token(CMD_NUM, 32'h8000_0000, 1'b0);
        send_token(CMD_NUM, 32'hFFFF_FFFF, 1'b0);
        send_token(CMD_DIV, $urandom, 1'b1);
        // truncating divide, multiply, line end on an empty token, divide by zero
        send_token(CMD_NUM, -32'sd7, 1'b0);
        send_token(CMD_NUM, 32'd2, 1'b0);
        send_token(CMD_DIV, $urandom, 1'b0);
        send_token(CMD_NUM, 32'd3, 1'b0);
        send_token(CMD_MUL, $urandom, 1'b0);
        send_token(CMD_NONE, $urandom, 1'b1);
        send_token(CMD_NUM, 32'd5, 1'b0);
        send_token(CMD_NUM, 32'd0, 1'b0);
        send_token(CMD_DIV, $urandom, 1'b1);
        // too few operands, malformed token, empty lines, too many operands
        send_token(CMD_NUM, 32'd1, 1'b0);
        send_token(CMD_ADD, $urandom, 1'b1);
        send_token(CMD_BAD, $urandom, 1'b1);
        send_token(CMD_NONE, $urandom, 1'b1);
        send_token(CMD_NUM, 32'd0, 1'b0);
        send_token(CMD_NUM, 32'd0, 1'b1);
        send_token(CMD_EQ, $urandom, 1'b1);
    endtask

    task automatic test_stack_limit();
        cmd_t c;
        res_mode = 2;
        // exactly full stack folds down to one value
        for (int k = 0; k < STACK_DEPTH; k++)
            send_token(CMD_NUM, pick_operand(), 1'b0);
        for (int k = 0; k < STACK_DEPTH - 1; k++)
        begin
            c = cmd_t'($urandom_range(CMD_ADD, CMD_MUL));
            send_token(c, $urandom, k == STACK_DEPTH - 2);
        end
        // one push past full overflows
        for (int k = 0; k <= STACK_DEPTH; k++)
            send_token(CMD_NUM, pick_operand(), 1'b0);
        send_token(CMD_ADD, $urandom, 1'b0);
        send_token(CMD_NONE, $urandom, 1'b1);
    endtask

    task automatic test_back_to_back();
        int stop_at;
        tok_gaps_on = 1'b0;
        res_mode    = 0;
        stop_at     = tokens_sent + 120;
        while (tokens_sent < stop_at)
            send_random_line();
    endtask

    task automatic test_random_lines();
        int lines;
        tok_gaps_on = 1'b1;
        lines       = 0;
        while (tokens_sent < 950)
        begin
            if (lines % 6 == 0)
            begin
                res_mode    = $urandom_range(0, 3);
                res_mask    = 8'($urandom_range(1, 255));
                tok_gaps_on = ($urandom_range(0, 3) != 0);
            end
            send_random_line();
            lines++;
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        tok_if.valid    = 1'b0;
        tok_if.cmd      = CMD_NONE;
        tok_if.operand  = '0;
        tok_if.line_end = 1'b0;
        res_if.ready    = 1'b0;
        res_mask        = 8'b1011_0010;
        res_mode        = 0;
        opnd_depth      = 0;
        line_closed     = 1'b0;
        line_code       = ST_OK;
        mismatch_count  = 0;
        tokens_sent     = 0;
        burst_left      = 0;
        tok_gaps_on     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        hold_until_drained();
        test_stack_limit();
        hold_until_drained();
        test_back_to_back();
        hold_until_drained();
        test_random_lines();
        hold_until_drained();

        // allow for a late divide or a stray beat
        repeat (60) @(posedge clk);
        if (line_results_due.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
